/* rtl/core/lss_pkg.sv */
// ----------------------------------------------------------------------------
// lss_pkg - shared types and constants for the literal substring search
// Field widths, register indexes and result status codes.
// ----------------------------------------------------------------------------
package lss_pkg;

    localparam int MAX_NEEDLE_DEF = 16;   // default needle capacity in bytes
    localparam int CFG_IDX_W      = 3;    // register index width
    localparam int CFG_DATA_W     = 64;   // widest register
    localparam int LEN_W          = 5;    // needle_length width
    localparam int OFS_W          = 48;   // file offset width
    localparam int SEEN_W         = 49;   // byte counter / match_end width

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NEEDLE_LOW      = 3'd0,
        REG_NEEDLE_HIGH     = 3'd1,
        REG_NEEDLE_LENGTH   = 3'd2,
        REG_SEARCH_BACKWARD = 3'd3,
        REG_WINDOW_START    = 3'd4
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_MATCH      = 2'd0,
        ST_NO_MATCH   = 2'd1,
        ST_BAD_NEEDLE = 2'd2
    } status_t;

endpackage

/* rtl/core/lss_match.sv */
// ----------------------------------------------------------------------------
// lss_match - parallel needle compare
// Compares the newest needle_length bytes of the window with the needle.
// ----------------------------------------------------------------------------
module lss_match #(
    parameter int MAX_NEEDLE = lss_pkg::MAX_NEEDLE_DEF
) (
    input  logic [MAX_NEEDLE-1:0][7:0]  window,   // newest byte at index 0
    input  logic [MAX_NEEDLE-1:0][7:0]  needle,
    input  logic [lss_pkg::LEN_W-1:0]   len,
    output logic                        equal
);
    import lss_pkg::*;

    logic [MAX_NEEDLE-1:0] byte_ok;

    // Needle byte i pairs with window byte len-1-i; bytes past len are don't-care.
    always_comb
    begin
        logic [LEN_W-1:0] pos;
        logic [7:0]       sel;
        for (int i = 0; i < MAX_NEEDLE; i++)
        begin
            pos = len - LEN_W'(1) - LEN_W'(i);
            sel = '0;
            for (int j = 0; j < MAX_NEEDLE; j++)
            begin
                if (pos == LEN_W'(j))
                begin
                    sel = window[j];
                end
            end
            byte_ok[i] = (LEN_W'(i) >= len) || (sel == needle[i]);
        end
    end

    assign equal = &byte_ok;

endmodule

/* rtl/core/literal_substring_search.sv */
// ----------------------------------------------------------------------------
// literal_substring_search - streaming exact substring search
// Finds a configured needle of up to MAX_NEEDLE bytes in a byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   Program the needle, its length, the direction and window_start through
//   the write port while the block is idle. Then stream the window text on
//   the input channel, one byte per transfer (has_byte marks a real byte).
//   The transfer with last_byte set closes the window and produces exactly
//   one result transfer: found, status, match_start and match_end.
//   Throughput: one input transfer per cycle while in_ready is high. Each byte
//   is shifted into a MAX_NEEDLE-byte window and compared with all needle
//   bytes in parallel in the cycle it is accepted.
//   The result is registered in the report stage when the last transfer is
//   accepted, then in the output register, which adds the offsets; it waits
//   in the report stage while the output register holds an unaccepted result.
//   When the receiver stalls, the result holds; text bytes keep flowing and
//   only a further last transfer waits while both result slots are full.
//   Reset clears the configuration, the byte count and match state, and
//   drops any pending result.
// ----------------------------------------------------------------------------
module literal_substring_search #(
    parameter int MAX_NEEDLE = lss_pkg::MAX_NEEDLE_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [lss_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lss_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [7:0]                       text_byte,
    input  logic                             has_byte,
    input  logic                             last_byte,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             found,
    output logic [1:0]                       status,
    output logic [lss_pkg::OFS_W-1:0]        match_start,
    output logic [lss_pkg::SEEN_W-1:0]       match_end
);
    import lss_pkg::*;

    // configuration
    logic [63:0]       needle_low_reg;
    logic [63:0]       needle_high_reg;
    logic [LEN_W-1:0]  needle_length_reg;
    logic              search_backward_reg;
    logic [OFS_W-1:0]  window_start_reg;

    // stream state
    logic [MAX_NEEDLE-1:0][7:0] recent_reg;
    logic [MAX_NEEDLE-1:0][7:0] recent_next;
    logic [SEEN_W-1:0]          bytes_seen_reg;
    logic [SEEN_W-1:0]          bytes_seen_next;
    logic                       have_match_reg;
    logic                       have_match_next;
    logic [OFS_W-1:0]           kept_start_reg;
    logic [OFS_W-1:0]           kept_start_next;

    // report stage
    logic              rpt_valid_reg;
    logic              rpt_valid_next;
    logic              rpt_have_reg;
    logic [OFS_W-1:0]  rpt_kept_reg;

    // output register
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              found_reg;
    status_t           status_reg;
    logic [OFS_W-1:0]  match_start_reg;
    logic [SEEN_W-1:0] match_end_reg;

    logic [MAX_NEEDLE-1:0][7:0] needle_bytes;
    logic [127:0]               needle_all;
    logic                       window_eq;
    logic                       len_ok;
    logic                       hit;
    logic                       take;
    logic [SEEN_W-1:0]          kept_diff;
    logic                       in_xfer;
    logic                       out_xfer;
    logic                       out_load;
    logic [OFS_W-1:0]           sum_start;
    logic [SEEN_W-1:0]          sum_end;

    //------------------------------------------------------------------
    // Configuration writes
    //------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            needle_low_reg      <= '0;
            needle_high_reg     <= '0;
            needle_length_reg   <= '0;
            search_backward_reg <= 1'b0;
            window_start_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_NEEDLE_LOW:      needle_low_reg      <= cfg_data;
                REG_NEEDLE_HIGH:     needle_high_reg     <= cfg_data;
                REG_NEEDLE_LENGTH:   needle_length_reg   <= cfg_data[LEN_W-1:0];
                REG_SEARCH_BACKWARD: search_backward_reg <= cfg_data[0];
                REG_WINDOW_START:    window_start_reg    <= cfg_data[OFS_W-1:0];
                default:             ;
            endcase
        end
    end

    assign needle_all = {needle_high_reg, needle_low_reg};

    always_comb
    begin
        for (int i = 0; i < MAX_NEEDLE; i++)
        begin
            needle_bytes[i] = needle_all[8*i +: 8];
        end
    end

    assign len_ok = (needle_length_reg != '0) &&
                    (needle_length_reg <= LEN_W'(MAX_NEEDLE));

    //------------------------------------------------------------------
    // Shift and compare
    //------------------------------------------------------------------
    always_comb
    begin
        recent_next[0] = text_byte;
        for (int k = 1; k < MAX_NEEDLE; k++)
        begin
            recent_next[k] = recent_reg[k-1];
        end
    end

    lss_match #(
        .MAX_NEEDLE (MAX_NEEDLE)
    ) u_match (
        .window (recent_next),
        .needle (needle_bytes),
        .len    (needle_length_reg),
        .equal  (window_eq)
    );

    assign in_xfer  = in_valid && in_ready;
    assign out_xfer = out_valid_reg && out_ready;
    assign out_load = rpt_valid_reg && (!out_valid_reg || out_ready);
    // Only a window close needs a free report slot.
    assign in_ready = !last_byte || !rpt_valid_reg || out_load;

    assign bytes_seen_next = (bytes_seen_reg == '1) ? bytes_seen_reg
                                                    : bytes_seen_reg + SEEN_W'(1);
    assign hit       = len_ok && (bytes_seen_next >= SEEN_W'(needle_length_reg)) &&
                       window_eq;
    assign take      = has_byte && hit && (!have_match_reg || search_backward_reg);
    assign kept_diff = bytes_seen_next - SEEN_W'(needle_length_reg);

    assign have_match_next = have_match_reg || take;
    assign kept_start_next = take ? kept_diff[OFS_W-1:0] : kept_start_reg;

    always_ff @(posedge clk)
    begin
        if (in_xfer && has_byte)
        begin
            recent_reg <= recent_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_seen_reg <= '0;
            have_match_reg <= 1'b0;
            kept_start_reg <= '0;
        end
        else if (in_xfer)
        begin
            if (last_byte)
            begin
                // close the window: clear for the next one
                bytes_seen_reg <= '0;
                have_match_reg <= 1'b0;
                kept_start_reg <= '0;
            end
            else if (has_byte)
            begin
                bytes_seen_reg <= bytes_seen_next;
                have_match_reg <= have_match_next;
                kept_start_reg <= kept_start_next;
            end
        end
    end

    //------------------------------------------------------------------
    // Report stage
    //------------------------------------------------------------------
    always_comb
    begin
        rpt_valid_next = rpt_valid_reg;
        if (in_xfer && last_byte)
        begin
            rpt_valid_next = 1'b1;
        end
        else if (out_load)
        begin
            rpt_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rpt_valid_reg <= 1'b0;
        end
        else
        begin
            rpt_valid_reg <= rpt_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer && last_byte)
        begin
            rpt_have_reg <= has_byte ? have_match_next : have_match_reg;
            rpt_kept_reg <= has_byte ? kept_start_next : kept_start_reg;
        end
    end

    //------------------------------------------------------------------
    // Output register
    //------------------------------------------------------------------
    assign sum_start = window_start_reg + rpt_kept_reg;
    assign sum_end   = {1'b0, sum_start} + SEEN_W'(needle_length_reg);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_xfer)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            if (!len_ok)
            begin
                found_reg       <= 1'b0;
                status_reg      <= ST_BAD_NEEDLE;
                match_start_reg <= '0;
                match_end_reg   <= '0;
            end
            else if (rpt_have_reg)
            begin
                found_reg       <= 1'b1;
                status_reg      <= ST_MATCH;
                match_start_reg <= sum_start;
                match_end_reg   <= sum_end;
            end
            else
            begin
                found_reg       <= 1'b0;
                status_reg      <= ST_NO_MATCH;
                match_start_reg <= '0;
                match_end_reg   <= '0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign found       = found_reg;
    assign status      = status_reg;
    assign match_start = match_start_reg;
    assign match_end   = match_end_reg;

    //------------------------------------------------------------------
    // Assertions
    //------------------------------------------------------------------
    a_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && last_byte |=> rpt_valid_reg && (bytes_seen_reg == '0) && !have_match_reg)
        else $error("window close did not load report or clear stream state");

    a_rpt_holds: assert property (@(posedge clk) disable iff (!rst_n)
        rpt_valid_reg && !out_load && !(in_xfer && last_byte) |=> rpt_valid_reg)
        else $error("pending report dropped");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && last_byte && rpt_valid_reg && !out_load |-> !in_ready)
        else $error("window close accepted with no free report slot");

    a_found_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (found_reg == (status_reg == ST_MATCH)))
        else $error("found and status disagree");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !found_reg |-> (match_start_reg == '0) && (match_end_reg == '0))
        else $error("offsets nonzero without a match");

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top - testbench for literal_substring_search
// Streams search windows through the block under random valid/ready pacing,
// predicts each window report from its own search state, and compares every
// report field by field. The needle, its length, the direction and the window
// base change between phases, including bad needles and offset wrap.
// ----------------------------------------------------------------------------
module tb_top;
    import lss_pkg::*;

    localparam int MAX_NEEDLE   = MAX_NEEDLE_DEF;
    localparam int RANDOM_ITEMS = 1050;

    typedef struct packed {
        logic [7:0] value;
        logic       has;
        logic       last;
    } text_item_t;

    typedef struct packed {
        logic             found;
        status_t          status;
        logic [OFS_W-1:0] match_start;
        logic [SEEN_W:1]  match_end;
    } search_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [7:0]            text_byte = '0;
    logic                  has_byte = 1'b0;
    logic                  last_byte = 1'b0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic                  found;
    logic [1:0]            status;
    logic [OFS_W-1:0]      match_start;
    logic [SEEN_W-1:0]     match_end;

    // register copies as the block holds them
    logic [63:0]      cur_needle_lo = '0;
    logic [63:0]      cur_needle_hi = '0;
    logic [LEN_W-1:0] cur_len = '0;
    logic             cur_backward = 1'b0;
    logic [OFS_W-1:0] cur_wstart = '0;

    // search state of the open window
    logic [7:0]        recent [MAX_NEEDLE];
    logic [SEEN_W-1:0] seen = '0;
    logic              have_hit = 1'b0;
    logic [OFS_W-1:0]  kept = '0;

    text_item_t     text_queue[$];
    search_result_t expected_reports[$];

    bit jitter_on = 1'b1;
    int alpha_mode = 0;
    int items_queued = 0;
    int transfers = 0;
    int stall_cycles = 0;
    int failures = 0;
    int settings_used = 0;
    int long_holds_asked = 0;
    int long_holds_done = 0;
    int tx_gap = 0;
    int rx_gap = 0;
    int hold_left = 0;
    int n_match = 0;
    int n_miss = 0;
    int n_bad = 0;

    literal_substring_search dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .text_byte   (text_byte),
        .has_byte    (has_byte),
        .last_byte   (last_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .found       (found),
        .status      (status),
        .match_start (match_start),
        .match_end   (match_end)
    );

    always #4 clk = ~clk;

    initial
    begin
        for (int i = 0; i < MAX_NEEDLE; i++)
            recent[i] = '0;
    end

    // Advance the search by one accepted transfer; a closing transfer
    // yields the window report.
    function automatic void search_window_byte(logic [7:0] b, logic h, logic l);
        logic [127:0]   pat;
        logic           eq;
        logic           len_ok;
        search_result_t r;
        pat = {cur_needle_hi, cur_needle_lo};
        len_ok = (cur_len >= 1) && (cur_len <= MAX_NEEDLE);
        if (h)
        begin
            for (int i = MAX_NEEDLE - 1; i > 0; i--)
                recent[i] = recent[i - 1];
            recent[0] = b;
            if (seen != '1)
                seen++;
            if (len_ok && seen >= cur_len)
            begin
                eq = 1'b1;
                for (int i = 0; i < cur_len; i++)
                    if (recent[cur_len - 1 - i] != pat[8 * i +: 8])
                        eq = 1'b0;
                if (eq && (!have_hit || cur_backward))
                begin
                    have_hit = 1'b1;
                    kept = seen - cur_len;
                end
            end
        end
        if (l)
        begin
            r.found = 1'b0;
            r.status = ST_NO_MATCH;
            r.match_start = '0;
            r.match_end = '0;
            if (!len_ok)
                r.status = ST_BAD_NEEDLE;
            else if (have_hit)
            begin
                r.found = 1'b1;
                r.status = ST_MATCH;
                r.match_start = cur_wstart + kept;
                r.match_end = {1'b0, r.match_start} + cur_len;
            end
            expected_reports.push_back(r);
            for (int i = 0; i < MAX_NEEDLE; i++)
                recent[i] = '0;
            seen = '0;
            have_hit = 1'b0;
            kept = '0;
        end
    endfunction

    // Sender: offer queued items, with random gaps between transfers.
    always @(posedge clk or negedge rst_n)
    begin
        text_item_t item;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            tx_gap = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                search_window_byte(text_byte, has_byte, last_byte);
                transfers++;
            end
            if (in_valid && !in_ready)
                stall_cycles++;
            if (!in_valid || in_ready)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap--;
                    in_valid <= 1'b0;
                end
                else if (text_queue.size() != 0)
                begin
                    item = text_queue.pop_front();
                    text_byte <= item.value;
                    has_byte <= item.has;
                    last_byte <= item.last;
                    in_valid <= 1'b1;
                    if (jitter_on && $urandom_range(0, 6) == 0)
                        tx_gap = $urandom_range(1, 13);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver: check each report transfer and pace out_ready.
    always @(posedge clk or negedge rst_n)
    begin
        search_result_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_gap = 0;
            hold_left = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_reports.size() == 0)
                begin
                    $error("unexpected report: found %0b status %0d start %0h end %0h",
                           found, status, match_start, match_end);
                    failures++;
                end
                else
                begin
                    want = expected_reports.pop_front();
                    if (found !== want.found)
                    begin
                        $error("found: expected %0h, got %0h", want.found, found);
                        failures++;
                    end
                    if (status !== want.status)
                    begin
                        $error("status: expected %0h, got %0h", want.status, status);
                        failures++;
                    end
                    if (match_start !== want.match_start)
                    begin
                        $error("match_start: expected %0h, got %0h",
                               want.match_start, match_start);
                        failures++;
                    end
                    if (match_end !== want.match_end)
                    begin
                        $error("match_end: expected %0h, got %0h", want.match_end, match_end);
                        failures++;
                    end
                    case (want.status)
                        ST_MATCH:    n_match++;
                        ST_NO_MATCH: n_miss++;
                        default:     n_bad++;
                    endcase
                end
            end
            if (long_holds_done < long_holds_asked)
            begin
                long_holds_done++;
                hold_left = 300;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (rx_gap > 0)
            begin
                rx_gap--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if (jitter_on && $urandom_range(0, 5) == 0)
                    rx_gap = $urandom_range(1, 13);
            end
        end
    end

    task automatic write_reg(cfg_reg_t idx, logic [63:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            REG_NEEDLE_LOW:      cur_needle_lo = value;
            REG_NEEDLE_HIGH:     cur_needle_hi = value;
            REG_NEEDLE_LENGTH:   cur_len = value[LEN_W-1:0];
            REG_SEARCH_BACKWARD: cur_backward = value[0];
            default:             cur_wstart = value[OFS_W-1:0];
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic setup_search(logic [63:0] lo, logic [63:0] hi, logic [LEN_W-1:0] len,
                                logic backward, logic [OFS_W-1:0] wstart);
        write_reg(REG_NEEDLE_LOW, lo);
        write_reg(REG_NEEDLE_HIGH, hi);
        write_reg(REG_NEEDLE_LENGTH, 64'(len));
        write_reg(REG_SEARCH_BACKWARD, 64'(backward));
        write_reg(REG_WINDOW_START, 64'(wstart));
        settings_used++;
    endtask

    task automatic push_item(logic [7:0] b, logic h, logic l);
        text_item_t item;
        item.value = b;
        item.has = h;
        item.last = l;
        text_queue.push_back(item);
        items_queued++;
    endtask

    // Wait until all queued items are sent, all reports are in and the block has settled.
    task automatic drain();
        while (text_queue.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_reports.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    function automatic logic [7:0] pick_text_byte();
        int r;
        r = $urandom_range(0, 9);
        if (alpha_mode == 0 || r >= 8)
            return 8'($urandom_range(0, 255));
        if (alpha_mode == 1)
            return r[0] ? 8'h61 : 8'h62;
        return 8'h61;
    endfunction

    task automatic random_setup();
        logic [127:0]     pat;
        logic [63:0]      wide;
        logic [LEN_W-1:0] len;
        logic [OFS_W-1:0] ws;
        int               pick;
        alpha_mode = $urandom_range(0, 2);
        for (int i = 0; i < 16; i++)
            pat[8 * i +: 8] = pick_text_byte();
        pick = $urandom_range(0, 19);
        if (pick == 0)
            len = '0;
        else if (pick == 1)
            len = LEN_W'($urandom_range(MAX_NEEDLE + 1, 31));
        else if (pick < 5)
            len = LEN_W'(MAX_NEEDLE);
        else if (pick < 11)
            len = LEN_W'($urandom_range(1, MAX_NEEDLE));
        else
            len = LEN_W'($urandom_range(1, 5));
        wide = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0:       ws = '0;
            1:       ws = '1 - OFS_W'($urandom_range(0, 40));
            2:       ws = wide[OFS_W-1:0];
            default: ws = OFS_W'($urandom_range(0, 1000));
        endcase
        setup_search(pat[63:0], pat[127:64], len, 1'($urandom_range(0, 1)), ws);
    endtask

    // Queue one window of text with planted needle copies and stray markers.
    task automatic queue_window(int n, bit close);
        logic [7:0]   body [];
        logic [127:0] pat;
        int           at;
        bit           end_marker;
        pat = {cur_needle_hi, cur_needle_lo};
        body = new[n];
        for (int i = 0; i < n; i++)
            body[i] = pick_text_byte();
        if (cur_len >= 1 && cur_len <= MAX_NEEDLE && n >= cur_len)
        begin
            repeat ($urandom_range(0, 2))
            begin
                at = $urandom_range(0, n - cur_len);
                for (int k = 0; k < cur_len; k++)
                    body[at + k] = pat[8 * k +: 8];
            end
        end
        end_marker = (n == 0) || ($urandom_range(0, 2) == 0);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 11) == 0)
                push_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            push_item(body[i], 1'b1, close && !end_marker && i == n - 1);
        end
        if (close && end_marker)
            push_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    initial
    begin
        int           phase;
        int           wait_cycles;
        int           n;
        logic [127:0] full_pat;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // registers still at reset: empty needle
        push_item(8'h00, 1'b0, 1'b1);
        drain();

        // "ab" forward: empty window, then first of two occurrences
        setup_search(64'h6261, 64'h0, 5'd2, 1'b0, 48'h0);
        push_item(8'hFF, 1'b0, 1'b1);
        push_item(8'h61, 1'b1, 1'b0);
        push_item(8'h62, 1'b1, 1'b0);
        push_item(8'h61, 1'b1, 1'b0);
        push_item(8'h62, 1'b1, 1'b1);
        drain();

        // "aaa" backward over "aaaa": rightmost overlapping hit
        setup_search(64'h616161, 64'h0, 5'd3, 1'b1, 48'd100);
        repeat (3) push_item(8'h61, 1'b1, 1'b0);
        push_item(8'h61, 1'b1, 1'b1);
        drain();

        // full-length needle at the top of the offset range
        setup_search(64'h00FF_00FF_A55A_F00F, 64'h8001_7F80_55AA_01FE, 5'd16, 1'b0, '1);
        full_pat = {cur_needle_hi, cur_needle_lo};
        for (int i = 0; i < 16; i++)
            push_item(full_pat[8 * i +: 8], 1'b1, i == 15);
        drain();

        // oversized needle length
        setup_search(64'h61, 64'h0, 5'd31, 1'b0, 48'h0);
        push_item(8'h61, 1'b1, 1'b1);
        drain();

        phase = 0;
        while (items_queued < RANDOM_ITEMS - 60)
        begin
            drain();
            random_setup();
            jitter_on = (phase % 6 != 5);
            if (phase == 8)
            begin
                // receiver holds off while short windows keep arriving
                jitter_on = 1'b0;
                long_holds_asked++;
                repeat (24) queue_window($urandom_range(0, 3), 1'b1);
            end
            repeat ($urandom_range(1, 5))
            begin
                n = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 48) : $urandom_range(0, 20);
                queue_window(n, 1'b1);
            end
            // leave a window open across the next reconfiguration
            if ($urandom_range(0, 7) == 0)
                queue_window($urandom_range(1, 10), 1'b0);
            phase++;
        end

        // closing stretch without idling on either side
        drain();
        jitter_on = 1'b0;
        random_setup();
        repeat (6) queue_window($urandom_range(0, 16), 1'b1);

        while (text_queue.size() != 0 || in_valid)
            @(posedge clk);
        wait_cycles = 0;
        while (expected_reports.size() != 0 && wait_cycles < 5000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (10) @(posedge clk);
        if (expected_reports.size() != 0)
        begin
            $error("%0d expected reports never arrived", expected_reports.size());
            failures++;
        end

        $display("Summary: %0d text transfers, %0d reports (%0d match, %0d no match, %0d bad)",
                 transfers, n_match + n_miss + n_bad, n_match, n_miss, n_bad);
        $display("Summary: %0d needle settings, %0d cycles with the input held off",
                 settings_used, stall_cycles);
        if (failures == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/lss_pkg.sv
rtl/core/lss_match.sv
rtl/core/literal_substring_search.sv
sim/tb_top.sv
